[design/paf_pkg.sv]
package paf_pkg;

   // Match table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int TABLE_IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int TABLE_CNT_W   = $clog2(TABLE_ENTRIES + 1);

   // Field widths
   localparam int KEY_W    = 128;
   localparam int HALF_W   = 64;
   localparam int SUM_W    = 48;
   localparam int LEN_W    = 16;
   localparam int KIND_W   = 3;
   localparam int CMD_W    = 2;
   localparam int ENTRY_W  = 4;
   localparam int COUNT_W  = 5;

   // Stream widths (tdata rounded up to whole bytes)
   localparam int REQ_TDATA_W = 296;
   localparam int REQ_TUSER_W = CMD_W + KIND_W;
   localparam int RSP_TDATA_W = 104;

   // CSR port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_KIND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_SRC   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_DST   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd3;

   // Commands
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PACKET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Header kinds
   localparam logic [KIND_W-1:0] KIND_MAC  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IPV4 = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IPV6 = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TCP  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UDP  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LAST = KIND_UDP;

   // Transport header sizes taken off the payload total
   localparam logic [SUM_W-1:0] TCP_HDR_BYTES = SUM_W'(20);
   localparam logic [SUM_W-1:0] UDP_HDR_BYTES = SUM_W'(8);

   typedef struct packed {
      logic                   en;
      logic [TABLE_IDX_W-1:0] addr;
      logic [KEY_W-1:0]       key;
   } paf_wr_type;

   typedef struct packed {
      logic                   start;
      logic                   match_src;
      logic                   match_dst;
      logic [TABLE_CNT_W-1:0] used;
   } paf_scan_req_type;

   typedef struct packed {
      logic done;
      logic hit;
   } paf_scan_rsp_type;

endpackage

[design/paf_table_scan.sv]
module paf_table_scan
   import paf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  paf_wr_type       wr,
   input  paf_scan_req_type scan_req,
   input  logic [KEY_W-1:0] src_key,
   input  logic [KEY_W-1:0] dst_key,
   output paf_scan_rsp_type scan_rsp
);

   logic [KEY_W-1:0] mem [TABLE_ENTRIES];

   logic                   active_ff, active_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   hit_ff, hit_in;
   logic [TABLE_CNT_W-1:0] issue_idx_ff, issue_idx_in;
   logic [TABLE_CNT_W-1:0] used_ff;
   logic                   match_src_ff;
   logic                   match_dst_ff;
   logic [KEY_W-1:0]       rd_data_ff;

   logic issuing;
   logic entry_hit;
   logic done;

   // one entry read per cycle, compared in the cycle after its read
   assign issuing   = active_ff && (issue_idx_ff < used_ff);
   assign entry_hit = rd_valid_ff &&
                      ((match_src_ff && (rd_data_ff == src_key)) ||
                       (match_dst_ff && (rd_data_ff == dst_key)));
   assign done      = active_ff && !issuing && !rd_valid_ff;

   always_comb begin
      active_in    = active_ff;
      rd_valid_in  = issuing;
      hit_in       = hit_ff || entry_hit;
      issue_idx_in = issue_idx_ff;
      if (issuing) begin
         issue_idx_in = issue_idx_ff + TABLE_CNT_W'(1);
      end
      if (done) begin
         active_in = 1'b0;
      end
      if (scan_req.start) begin
         active_in    = 1'b1;
         rd_valid_in  = 1'b0;
         hit_in       = 1'b0;
         issue_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         issue_idx_ff <= '0;
      end else begin
         active_ff    <= active_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         issue_idx_ff <= issue_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_req.start) begin
         used_ff      <= scan_req.used;
         match_src_ff <= scan_req.match_src;
         match_dst_ff <= scan_req.match_dst;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.key;
      end
   end

   always_ff @(posedge clock) begin
      if (issuing) begin
         rd_data_ff <= mem[issue_idx_ff[TABLE_IDX_W-1:0]];
      end
   end

   assign scan_rsp.done = done;
   assign scan_rsp.hit  = hit_ff;

endmodule

[design/packet_address_filter_core.sv]
// Channel   Direction  Transfer carries
// req_*     in         load entry / packet / clear-totals command with keys and lengths
// rsp_*     out        one result per request: match flags and both byte totals
// csr_*     in         register writes: filter kind, side selects, entry count
//
// Load, clear and non-scanned packets go straight from the request to the result; a
//   scanned packet first reads entry_count entries, capped at the table size, through
//   the single read port of the match table (one per cycle).
// One request at a time; the next is taken as soon as its result is in the
//   output register, even if that result is still stalled.
// Reset clears the totals and registers; table contents stay undefined until loaded.
// csr writes are always ready and are expected only while the core is idle.
module packet_address_filter_core
   import paf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // entry_index, src_hi, src_lo, dst_hi, dst_lo, frame_length, payload_length
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd, header_kind
   input  logic [REQ_TUSER_W-1:0] req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // kind_matched, accepted, frame_byte_total, payload_byte_total
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // request fields
   logic [CMD_W-1:0]   f_cmd;
   logic [KIND_W-1:0]  f_kind;
   logic [ENTRY_W-1:0] f_entry;
   logic [KEY_W-1:0]   f_src;
   logic [KEY_W-1:0]   f_dst;
   logic [LEN_W-1:0]   f_flen;
   logic [LEN_W-1:0]   f_plen;

   assign f_cmd   = req_tuser[1:0];
   assign f_kind  = req_tuser[4:2];
   assign f_entry = req_tdata[3:0];
   assign f_src   = {req_tdata[67:4], req_tdata[131:68]};
   assign f_dst   = {req_tdata[195:132], req_tdata[259:196]};
   assign f_flen  = req_tdata[275:260];
   assign f_plen  = req_tdata[291:276];

   // config registers
   logic [KIND_W-1:0]  filter_kind_ff;
   logic               match_src_ff;
   logic               match_dst_ff;
   logic [COUNT_W-1:0] entry_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_kind_ff <= KIND_MAC;
         match_src_ff   <= 1'b0;
         match_dst_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FILTER_KIND: filter_kind_ff <= csr_wdata[KIND_W-1:0];
            CSR_MATCH_SRC:   match_src_ff   <= csr_wdata[0];
            CSR_MATCH_DST:   match_dst_ff   <= csr_wdata[0];
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // entries in use, capped at the table size
   logic [TABLE_CNT_W-1:0] used;
   always_comb begin
      if (32'(entry_count_ff) > TABLE_ENTRIES) begin
         used = TABLE_CNT_W'(TABLE_ENTRIES);
      end else begin
         used = TABLE_CNT_W'(entry_count_ff);
      end
   end

   // control
   logic [1:0] state_ff, state_in;
   logic       req_xfer;
   logic       kind_ok;
   logic       need_scan;
   logic       rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign kind_ok    = (f_cmd == CMD_PACKET) && (f_kind <= KIND_LAST) &&
                       (f_kind == filter_kind_ff);
   assign need_scan  = kind_ok && (match_src_ff || match_dst_ff) &&
                       (used != '0);

   paf_wr_type       tbl_wr;
   paf_scan_req_type scan_req;
   paf_scan_rsp_type scan_rsp;

   // loads go straight to the table; no scan can be running then
   assign tbl_wr.en   = req_xfer && (f_cmd == CMD_LOAD) &&
                        (32'(f_entry) < TABLE_ENTRIES);
   assign tbl_wr.addr = TABLE_IDX_W'(f_entry);
   assign tbl_wr.key  = f_src;

   assign scan_req.start     = req_xfer && need_scan;
   assign scan_req.match_src = match_src_ff;
   assign scan_req.match_dst = match_dst_ff;
   assign scan_req.used      = used;

   // item held for the whole scan
   logic [CMD_W-1:0]  cmd_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [KEY_W-1:0]  src_key_ff;
   logic [KEY_W-1:0]  dst_key_ff;
   logic [LEN_W-1:0]  flen_ff;
   logic [LEN_W-1:0]  plen_ff;
   logic              kind_ok_ff;
   logic              scanned_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff     <= f_cmd;
         kind_ff    <= f_kind;
         src_key_ff <= f_src;
         dst_key_ff <= f_dst;
         flen_ff    <= f_flen;
         plen_ff    <= f_plen;
         kind_ok_ff <= kind_ok;
         scanned_ff <= need_scan;
      end
   end

   paf_table_scan u_table_scan (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .scan_req (scan_req),
      .src_key  (src_key_ff),
      .dst_key  (dst_key_ff),
      .scan_rsp (scan_rsp)
   );

   logic rsp_valid_ff, rsp_valid_in;

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = need_scan ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // totals
   logic             accepted;
   logic [SUM_W-1:0] hdr_bytes;
   logic [SUM_W-1:0] frame_sum_ff, frame_sum_in;
   logic [SUM_W-1:0] payload_sum_ff, payload_sum_in;

   assign accepted = kind_ok_ff && scanned_ff && scan_rsp.hit;

   always_comb begin
      case (kind_ff)
         KIND_TCP: hdr_bytes = TCP_HDR_BYTES;
         KIND_UDP: hdr_bytes = UDP_HDR_BYTES;
         default:  hdr_bytes = '0;
      endcase
   end

   always_comb begin
      frame_sum_in   = frame_sum_ff;
      payload_sum_in = payload_sum_ff;
      if (cmd_ff == CMD_CLEAR) begin
         frame_sum_in   = '0;
         payload_sum_in = '0;
      end else if (accepted) begin
         frame_sum_in   = frame_sum_ff + SUM_W'(flen_ff);
         payload_sum_in = payload_sum_ff + SUM_W'(plen_ff) - hdr_bytes;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         frame_sum_ff   <= '0;
         payload_sum_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            frame_sum_ff   <= frame_sum_in;
            payload_sum_ff <= payload_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {6'b0, payload_sum_in, frame_sum_in, accepted, kind_ok_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[design/paf_checker.sv]
module paf_checker
   import paf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a counted packet always had a matching kind
   a_acc_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[1] || rsp_tdata[0])
      else $error("accepted without kind match");

   // one request in flight: busy right after a transfer
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // no result straight out of reset
   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind packet_address_filter_core paf_checker u_paf_checker (.*);
